FILE: design/crsp_pkg.sv
package crsp_pkg;

   localparam int unsigned ChanW     = 16;
   localparam int unsigned CovW      = 17;
   localparam int unsigned SqW       = 34;   // square of a 17 bit magnitude
   localparam int unsigned SumW      = 34;   // 4x^2 + 4y^2 + z^2 < 2^34
   localparam int unsigned AccW      = 68;   // t^2 * S and its partial terms
   localparam int unsigned NormSteps = 15;   // one result bit per stage
   localparam int unsigned RhsShift  = 30;   // (2 * 16384)^2

   localparam logic [CovW-1:0] CovOne    = 17'd65536;
   localparam logic [6:0]      EdgeGain  = 7'd100;    // 1 / 0.01
   localparam logic [15:0]     RoundHalf = 16'd32768;

   typedef enum logic [1:0] {
      CSR_WIDTH,
      CSR_RED,
      CSR_GREEN,
      CSR_BLUE
   } csr_index_type;

   typedef struct packed {
      logic [ChanW-1:0] width;
      logic [ChanW-1:0] red;
      logic [ChanW-1:0] green;
      logic [ChanW-1:0] blue;
   } cfg_type;

   typedef struct packed {
      logic [ChanW-1:0]        distance;
      logic [ChanW-1:0]        albedo_red;
      logic [ChanW-1:0]        albedo_green;
      logic [ChanW-1:0]        albedo_blue;
      logic signed [ChanW-1:0] normal_x;
      logic signed [ChanW-1:0] normal_y;
      logic signed [ChanW-1:0] normal_z;
   } req_type;

   typedef struct packed {
      logic [ChanW-1:0]        shaded_red;
      logic [ChanW-1:0]        shaded_green;
      logic [ChanW-1:0]        shaded_blue;
      logic signed [ChanW-1:0] out_normal_x;
      logic signed [ChanW-1:0] out_normal_y;
      logic signed [ChanW-1:0] out_normal_z;
      logic [CovW-1:0]         coverage;
   } rsp_type;

   // per-item data that rides alongside the normalizer
   typedef struct packed {
      logic [ChanW-1:0]        shaded_red;
      logic [ChanW-1:0]        shaded_green;
      logic [ChanW-1:0]        shaded_blue;
      logic signed [ChanW-1:0] normal_x;
      logic signed [ChanW-1:0] normal_y;
      logic signed [ChanW-1:0] normal_z;
      logic [2:0]              neg;
      logic                    on_edge;
      logic                    zero_len;
      logic [CovW-1:0]         coverage;
   } side_type;

   typedef struct packed {
      side_type          side;
      logic [SumW-1:0]   len_sq;
      logic [SqW-1:0]    sq_x;
      logic [SqW-1:0]    sq_y;
      logic [SqW-1:0]    sq_z;
   } front_type;

   function automatic logic [CovW-1:0] mag17(input logic [CovW-1:0] v);
      return v[CovW-1] ? (~v + 17'd1) : v;
   endfunction

   function automatic logic [ChanW-1:0] blend(input logic [ChanW-1:0] a,
                                              input logic [ChanW-1:0] c,
                                              input logic [CovW-1:0]  cov);
      logic [33:0] acc;
      acc = 34'(a) * 34'(CovOne - cov) + 34'(c) * 34'(cov) + 34'(RoundHalf);
      return acc[31:16];
   endfunction

endpackage

FILE: design/crsp_if.sv
interface crsp_req_if;
   import crsp_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface crsp_rsp_if;
   import crsp_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: design/crsp_front.sv
module crsp_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  crsp_pkg::req_type   in_data,
   input  crsp_pkg::cfg_type   cfg,
   output logic                out_valid,
   output crsp_pkg::front_type out_data
);
   import crsp_pkg::*;

   // stage 1: coverage and squared components
   logic [ChanW-1:0] diff;
   logic [22:0]      scaled;
   logic [CovW-1:0]  cov_in;
   logic [CovW-1:0]  mx, my, mz;

   logic             v1_ff;
   logic [CovW-1:0]  cov1_ff;
   req_type          px1_ff;
   logic [SqW-1:0]   sqx1_ff, sqy1_ff, sqz1_ff;

   always_comb begin
      diff   = cfg.width - in_data.distance;
      scaled = 23'(diff) * 23'(EdgeGain);
      cov_in = '0;
      if (in_data.distance < cfg.width) begin
         cov_in = (scaled > 23'(CovOne)) ? CovOne : scaled[CovW-1:0];
      end
      mx = mag17({in_data.normal_x, 1'b0});
      my = mag17({in_data.normal_y, 1'b0});
      mz = mag17({in_data.normal_z[ChanW-1], in_data.normal_z});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
      end
      if (en) begin
         cov1_ff <= cov_in;
         px1_ff  <= in_data;
         sqx1_ff <= SqW'(mx) * SqW'(mx);
         sqy1_ff <= SqW'(my) * SqW'(my);
         sqz1_ff <= SqW'(mz) * SqW'(mz);
      end
   end

   // stage 2: colour blend and squared length
   front_type f_in;
   logic      v2_ff;
   front_type f2_ff;

   always_comb begin
      f_in.side.shaded_red   = blend(px1_ff.albedo_red, cfg.red, cov1_ff);
      f_in.side.shaded_green = blend(px1_ff.albedo_green, cfg.green, cov1_ff);
      f_in.side.shaded_blue  = blend(px1_ff.albedo_blue, cfg.blue, cov1_ff);
      f_in.side.normal_x     = px1_ff.normal_x;
      f_in.side.normal_y     = px1_ff.normal_y;
      f_in.side.normal_z     = px1_ff.normal_z;
      f_in.side.neg          = {px1_ff.normal_z[ChanW-1], px1_ff.normal_y[ChanW-1],
                                px1_ff.normal_x[ChanW-1]};
      f_in.side.on_edge      = (cov1_ff != '0) && (cov1_ff != CovOne);
      f_in.len_sq            = SumW'(sqx1_ff) + SumW'(sqy1_ff) + SumW'(sqz1_ff);
      f_in.side.zero_len     = (f_in.len_sq == '0);
      f_in.side.coverage     = cov1_ff;
      f_in.sq_x              = sqx1_ff;
      f_in.sq_y              = sqy1_ff;
      f_in.sq_z              = sqz1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
      if (en) begin
         f2_ff <= f_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_data  = f2_ff;

endmodule

FILE: design/crsp_norm_lane.sv
module crsp_norm_lane (
   input  logic                               clock,
   input  logic                               en,
   input  logic [crsp_pkg::SumW-1:0]          len_sq,
   input  logic [crsp_pkg::SqW-1:0]           mag_sq,
   output logic [crsp_pkg::NormSteps-1:0]     result
);
   import crsp_pkg::*;

   // Greedy bit search for the largest r with (2r-1)^2 * S <= m^2 * 2^30.
   // A = (2r)^2 * S and B = 2r * S are kept so each step is shifts and adds.
   logic [AccW-1:0]      a_st   [0:NormSteps];
   logic [AccW-1:0]      b_st   [0:NormSteps];
   logic [AccW-1:0]      s_st   [0:NormSteps];
   logic [AccW-1:0]      rhs_st [0:NormSteps];
   logic [NormSteps-1:0] r_st   [0:NormSteps];

   assign a_st[0]   = '0;
   assign b_st[0]   = '0;
   assign s_st[0]   = AccW'(len_sq);
   assign rhs_st[0] = AccW'(mag_sq) << RhsShift;
   assign r_st[0]   = '0;

   for (genvar j = 0; j < NormSteps; j++) begin : g_step
      localparam int unsigned K = NormSteps - 1 - j;

      logic [AccW-1:0]      a_cand, b_cand, test;
      logic [AccW-1:0]      a_in, b_in;
      logic [NormSteps-1:0] r_in;
      logic [AccW-1:0]      a_ff, b_ff, s_ff, rhs_ff;
      logic [NormSteps-1:0] r_ff;

      always_comb begin
         b_cand = b_st[j] + (s_st[j] << (K + 1));
         a_cand = a_st[j] + (b_st[j] << (K + 2)) + (s_st[j] << (2 * K + 2));
         test   = a_cand - (b_cand << 1) + s_st[j];
         if (test <= rhs_st[j]) begin
            a_in = a_cand;
            b_in = b_cand;
            r_in = r_st[j] | (NormSteps'(1) << K);
         end else begin
            a_in = a_st[j];
            b_in = b_st[j];
            r_in = r_st[j];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            a_ff   <= a_in;
            b_ff   <= b_in;
            s_ff   <= s_st[j];
            rhs_ff <= rhs_st[j];
            r_ff   <= r_in;
         end
      end

      assign a_st[j+1]   = a_ff;
      assign b_st[j+1]   = b_ff;
      assign s_st[j+1]   = s_ff;
      assign rhs_st[j+1] = rhs_ff;
      assign r_st[j+1]   = r_ff;
   end

   assign result = r_st[NormSteps];

endmodule

FILE: design/crack_shading_pixel.sv
// Crack shading, one pixel per item.
//
// req_chan carries a pixel: crack distance, albedo RGB and a Q1.14 normal.
// rsp_chan returns one item per pixel: blended RGB, resulting normal and
// the crack coverage (65536 = fully inside). Items leave in arrival order.
// The csr_ port writes crack width and crack colour; write it only while
// no item is in flight.
//
// Throughput: one item per cycle while the receiver keeps taking them. The pipe
// holds two front stages (coverage/squares, blend/length), fifteen
// normalizer stages that each settle one bit of the unit-length result,
// and the output register.
//
// The whole pipe advances together: it moves whenever the output register
// is empty or being taken, so a stalled receiver freezes every stage and
// drops req_chan.ready; nothing is lost or repeated.
//
// Reset clears all valid bits and the configuration registers to zero.
module crack_shading_pixel (
   input  logic                        clock,
   input  logic                        reset,
   crsp_req_if.sink                    req_chan,
   crsp_rsp_if.source                  rsp_chan,
   input  logic                        csr_we,
   input  crsp_pkg::csr_index_type     csr_index,
   input  logic [crsp_pkg::ChanW-1:0]  csr_wdata
);
   import crsp_pkg::*;

   // configuration registers
   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WIDTH: cfg_ff.width <= csr_wdata;
            CSR_RED:   cfg_ff.red   <= csr_wdata;
            CSR_GREEN: cfg_ff.green <= csr_wdata;
            CSR_BLUE:  cfg_ff.blue  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // global advance: output register empty or draining
   logic    en;
   logic    out_valid_ff;
   rsp_type out_data_ff;

   assign en             = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = en;

   // front end: coverage, blend, squared length
   logic      front_valid;
   front_type front_data;

   crsp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_chan.valid),
      .in_data   (req_chan.data),
      .cfg       (cfg_ff),
      .out_valid (front_valid),
      .out_data  (front_data)
   );

   // one normalizer lane per component of (2x, 2y, z)
   logic [NormSteps-1:0] r_x, r_y, r_z;

   crsp_norm_lane u_lane_x (
      .clock (clock), .en (en), .len_sq (front_data.len_sq),
      .mag_sq (front_data.sq_x), .result (r_x)
   );
   crsp_norm_lane u_lane_y (
      .clock (clock), .en (en), .len_sq (front_data.len_sq),
      .mag_sq (front_data.sq_y), .result (r_y)
   );
   crsp_norm_lane u_lane_z (
      .clock (clock), .en (en), .len_sq (front_data.len_sq),
      .mag_sq (front_data.sq_z), .result (r_z)
   );

   // sideband delay matched to the lanes
   logic     vld_ff  [0:NormSteps-1];
   side_type side_ff [0:NormSteps-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NormSteps; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= front_valid;
         for (int i = 1; i < NormSteps; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
      if (en) begin
         side_ff[0] <= front_data.side;
         for (int i = 1; i < NormSteps; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   // output stage: apply sign, pick normalized or passed-through normal
   side_type         side_end;
   logic [ChanW-1:0] ux, uy, uz;
   rsp_type          out_in;

   always_comb begin
      side_end = side_ff[NormSteps-1];
      ux = ChanW'(r_x);
      uy = ChanW'(r_y);
      uz = ChanW'(r_z);
      out_in.shaded_red   = side_end.shaded_red;
      out_in.shaded_green = side_end.shaded_green;
      out_in.shaded_blue  = side_end.shaded_blue;
      out_in.coverage     = side_end.coverage;
      out_in.out_normal_x = side_end.normal_x;
      out_in.out_normal_y = side_end.normal_y;
      out_in.out_normal_z = side_end.normal_z;
      if (side_end.on_edge) begin
         if (side_end.zero_len) begin
            // zero-length normal: halved input is all zero
            out_in.out_normal_x = '0;
            out_in.out_normal_y = '0;
            out_in.out_normal_z = '0;
         end else begin
            out_in.out_normal_x = side_end.neg[0] ? -ux : ux;
            out_in.out_normal_y = side_end.neg[1] ? -uy : uy;
            out_in.out_normal_z = side_end.neg[2] ? -uz : uz;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= vld_ff[NormSteps-1];
      end
      if (en) begin
         out_data_ff <= out_in;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.data  = out_data_ff;

endmodule

FILE: tb/sv/crack_shading_pixel_tb.sv
`timescale 1ns / 1ps

module crack_shading_pixel_tb;
   import crsp_pkg::*;

   logic clock;
   logic reset;
   logic csr_we;
   csr_index_type csr_index;
   logic [ChanW-1:0] csr_wdata;

   crsp_req_if req_chan ();
   crsp_rsp_if rsp_chan ();

   crack_shading_pixel DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan.sink),
      .rsp_chan  (rsp_chan.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   localparam int unsigned PipeDepth = 18;
   localparam int unsigned StallLimit = 5000;

   // shadow copy of the crack setup
   logic [15:0] shd_width, shd_red, shd_green, shd_blue;

   rsp_type pixel_queue[$];
   int unsigned mismatch_count;
   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;
   int unsigned quiet_cycles;

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // round(|c| * 16384 / sqrt(s)), ties away from zero, by bisection
   function automatic logic signed [15:0] unit_comp(input longint c, input longint s);
      longint mag, rhs, t;
      int lo, hi, mid;
      mag = (c < 0) ? -c : c;
      rhs = (mag * mag) << 30;
      lo = 0;
      hi = 16384;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         t = 2 * mid - 1;
         // t*t*s can exceed 64 bits; compare via 128-bit math
         if (128'(t * t) * 128'(s) <= 128'(rhs)) begin
            lo = mid;
         end else begin
            hi = mid - 1;
         end
      end
      return (c < 0) ? 16'(-lo) : 16'(lo);
   endfunction

   function automatic logic [15:0] mix_chan(input logic [15:0] a, input logic [15:0] c,
                                            input logic [16:0] cov);
      logic [47:0] acc;
      acc = 48'(a) * 48'(65536 - cov) + 48'(c) * 48'(cov) + 48'd32768;
      return acc[31:16];
   endfunction

   function automatic rsp_type shade_pixel(input req_type px);
      rsp_type r;
      logic [31:0] d;
      longint cx, cy, cz, s;
      r.coverage = '0;
      if (px.distance < shd_width) begin
         d = (32'(shd_width) - 32'(px.distance)) * 32'd100;
         r.coverage = (d > 32'd65536) ? 17'd65536 : d[16:0];
      end
      r.shaded_red   = mix_chan(px.albedo_red, shd_red, r.coverage);
      r.shaded_green = mix_chan(px.albedo_green, shd_green, r.coverage);
      r.shaded_blue  = mix_chan(px.albedo_blue, shd_blue, r.coverage);
      r.out_normal_x = px.normal_x;
      r.out_normal_y = px.normal_y;
      r.out_normal_z = px.normal_z;
      if (r.coverage > 0 && r.coverage < 17'd65536) begin
         // halving z then normalizing == normalizing (2x, 2y, z)
         cx = 2 * longint'(px.normal_x);
         cy = 2 * longint'(px.normal_y);
         cz = longint'(px.normal_z);
         s = cx * cx + cy * cy + cz * cz;
         if (s != 0) begin
            r.out_normal_x = unit_comp(cx, s);
            r.out_normal_y = unit_comp(cy, s);
            r.out_normal_z = unit_comp(cz, s);
         end else begin
            r.out_normal_x = '0;
            r.out_normal_y = '0;
            r.out_normal_z = '0;
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // receiver: random stalls and per-field check against the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = rsp_chan.data;
            if (pixel_queue.size() == 0) begin
               report_mismatch("unexpected item", 1, 0);
            end else begin
               want = pixel_queue.pop_front();
               if (got.shaded_red !== want.shaded_red)
                  report_mismatch("shaded_red", got.shaded_red, want.shaded_red);
               if (got.shaded_green !== want.shaded_green)
                  report_mismatch("shaded_green", got.shaded_green, want.shaded_green);
               if (got.shaded_blue !== want.shaded_blue)
                  report_mismatch("shaded_blue", got.shaded_blue, want.shaded_blue);
               if (got.out_normal_x !== want.out_normal_x)
                  report_mismatch("out_normal_x", got.out_normal_x, want.out_normal_x);
               if (got.out_normal_y !== want.out_normal_y)
                  report_mismatch("out_normal_y", got.out_normal_y, want.out_normal_y);
               if (got.out_normal_z !== want.out_normal_z)
                  report_mismatch("out_normal_z", got.out_normal_z, want.out_normal_z);
               if (got.coverage !== want.coverage)
                  report_mismatch("coverage", got.coverage, want.coverage);
            end
         end
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // watchdog: cycles with no item moving on either side
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= StallLimit) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // write enable stays high across a burst; the caller drops it
   task automatic write_csr(input csr_index_type idx, input logic [15:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_WIDTH: shd_width = val;
         CSR_RED:   shd_red   = val;
         CSR_GREEN: shd_green = val;
         CSR_BLUE:  shd_blue  = val;
         default: ;
      endcase
   endtask

   task automatic set_crack(input logic [15:0] w, input logic [15:0] r,
                            input logic [15:0] g, input logic [15:0] b);
      write_csr(CSR_WIDTH, w);
      write_csr(CSR_RED, r);
      write_csr(CSR_GREEN, g);
      write_csr(CSR_BLUE, b);
      csr_we <= 1'b0;
   endtask

   // sends one item; valid stays high across back-to-back items
   task automatic send_pixel(input req_type px);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.data  <= px;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      pixel_queue.push_back(shade_pixel(px));
   endtask

   task automatic drain;
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pixel_queue.size() != 0) @(posedge clock);
      repeat (PipeDepth + 2) @(posedge clock);
   endtask

   function automatic req_type rand_pixel(input logic [15:0] w);
      req_type px;
      px = req_type'({$urandom, $urandom, $urandom, $urandom});
      // mostly land on the soft edge, where the normalizer works
      case ($urandom_range(3))
         0, 1: px.distance = (w > 16'd656) ? w - 16'($urandom_range(1, 655)) : 16'($urandom);
         2: px.distance = w - 16'($urandom_range(0, 3000));
         default: ;
      endcase
      if ($urandom_range(9) == 0) begin
         px.normal_x = '0;
         px.normal_y = '0;
         px.normal_z = '0;
      end
      return px;
   endfunction

   task automatic test_directed;
      req_type px;
      set_crack(16'hFFFF, 16'h0000, 16'hFFFF, 16'h8000);
      // edge, full coverage, outside, zero normal, extreme normals
      px = '{16'hFFFE, 16'hFFFF, 16'h0000, 16'h1234, 16'sh7FFF, 16'sh8000, 16'sh4000};
      send_pixel(px);
      px.distance = 16'h0000;
      send_pixel(px);
      px.distance = 16'hFFFF;
      send_pixel(px);
      px = '{16'hFF00, 16'h0000, 16'hFFFF, 16'hFFFF, 16'sh0000, 16'sh0000, 16'sh0000};
      send_pixel(px);
      px = '{16'hFFF0, 16'hFFFF, 16'hFFFF, 16'h0000, 16'sh8000, 16'sh8000, 16'sh8000};
      send_pixel(px);
      px = '{16'hFFF0, 16'h8000, 16'h7FFF, 16'h0001, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF};
      send_pixel(px);
      px = '{16'hFFF0, 16'h8000, 16'h7FFF, 16'h0001, 16'sh0000, 16'sh0000, 16'sh8000};
      send_pixel(px);
      // last step below full coverage: 655 * 100 = 65500
      px = '{16'hFFFF - 16'd655, 16'h5555, 16'hAAAA, 16'h0F0F, 16'sh0001, 16'shFFFF, 16'sh0000};
      send_pixel(px);
      px.distance = 16'hFFFF - 16'd656;
      send_pixel(px);
      drain();
      // width 0: nothing is ever in the crack
      set_crack(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
      px = '{16'h0000, 16'h1111, 16'h2222, 16'h3333, 16'sh4000, 16'sh0000, 16'sh0000};
      send_pixel(px);
      drain();
   endtask

   task automatic test_random(input int unsigned count, input int unsigned idle,
                              input int unsigned stall);
      send_idle_pct  = idle;
      recv_stall_pct = stall;
      set_crack(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      for (int unsigned i = 0; i < count; i++) begin
         send_pixel(rand_pixel(shd_width));
      end
      drain();
   endtask

   task automatic test_pause;
      send_idle_pct  = 0;
      recv_stall_pct = 30;
      set_crack(16'd1000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      repeat (20) send_pixel(rand_pixel(shd_width));
      // hold off until the pipe is empty, then resume
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pixel_queue.size() != 0) @(posedge clock);
      repeat (20) send_pixel(rand_pixel(shd_width));
      drain();
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_WIDTH;
      csr_wdata = '0;
      req_chan.valid = 1'b0;
      req_chan.data = '0;
      rsp_chan.ready = 1'b0;
      shd_width = '0;
      shd_red = '0;
      shd_green = '0;
      shd_blue = '0;
      mismatch_count = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random(400, 0, 0);
      test_random(300, 81, 0);
      test_random(300, 0, 81);
      test_random(300, 20, 20);
      test_pause();
      test_random(350, $urandom_range(0, 50), $urandom_range(0, 50));

      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
